>>> rtl/core/ecdt_pkg.sv
// Shared constants and codes for the city distance table.
package ecdt_pkg;

    localparam int ECDT_MAX_CITIES = 1024;
    localparam int ECDT_COORD_BITS = 24;

    localparam int INDEX_W = 10;
    localparam int COUNT_W = 11;
    localparam int SPAN_W  = 25;

    localparam logic KIND_WRITE = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

endpackage

>>> rtl/core/ecdt_if.sv
// Request and response channel interfaces for the city distance table.
interface ecdt_req_if
    import ecdt_pkg::*;
#(
    parameter int COORD_BITS = ECDT_COORD_BITS
) ();
    logic                         valid;
    logic                         ready;
    logic                         kind;
    logic [INDEX_W-1:0]           city_index;
    logic signed [COORD_BITS-1:0] coord_x;
    logic signed [COORD_BITS-1:0] coord_y;
    logic [INDEX_W-1:0]           from_city;
    logic [INDEX_W-1:0]           to_city;

    modport source (
        output valid, kind, city_index, coord_x, coord_y, from_city, to_city,
        input  ready
    );
    modport sink (
        input  valid, kind, city_index, coord_x, coord_y, from_city, to_city,
        output ready
    );
endinterface

interface ecdt_rsp_if
    import ecdt_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [SPAN_W-1:0] span;
    logic              bad_index;

    modport source (output valid, span, bad_index, input ready);
    modport sink   (input valid, span, bad_index, output ready);
endinterface

>>> rtl/core/ecdt_sqrt.sv
// Bit-serial integer square root with round-to-nearest on the remainder.
module ecdt_sqrt
    import ecdt_pkg::*;
#(
    parameter int COORD_BITS = ECDT_COORD_BITS
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [2*COORD_BITS:0]     radicand,
    output logic                      busy,
    output logic                      done,
    output logic [COORD_BITS:0]       root
);

    localparam int ROOT_W = COORD_BITS + 1;
    localparam int SQ_W   = 2 * ROOT_W;
    localparam int CNT_W  = $clog2(ROOT_W + 1);

    logic [SQ_W-1:0]   rem_reg,  rem_next;
    logic [SQ_W-1:0]   acc_reg,  acc_next;
    logic [SQ_W-1:0]   bit_reg,  bit_next;
    logic [CNT_W-1:0]  cnt_reg,  cnt_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [ROOT_W-1:0] root_reg, root_next;

    logic [SQ_W:0]     trial;
    logic [ROOT_W-1:0] acc_low;

    assign trial   = {1'b0, acc_reg} + {1'b0, bit_reg};
    assign acc_low = acc_reg[ROOT_W-1:0];

    always_comb
    begin
        rem_next  = rem_reg;
        acc_next  = acc_reg;
        bit_next  = bit_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        root_next = root_reg;
        if (start)
        begin
            rem_next  = SQ_W'(radicand);
            acc_next  = '0;
            bit_next  = {2'b01, {(SQ_W-2){1'b0}}};
            cnt_next  = CNT_W'(ROOT_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (cnt_reg != '0)
            begin
                // one root bit per step
                if ({1'b0, rem_reg} >= trial)
                begin
                    rem_next = rem_reg - trial[SQ_W-1:0];
                    acc_next = (acc_reg >> 1) + bit_reg;
                end
                else
                begin
                    acc_next = acc_reg >> 1;
                end
                bit_next = bit_reg >> 2;
                cnt_next = cnt_reg - 1'b1;
            end
            else
            begin
                // round up when s - r*r exceeds r
                root_next = acc_low + ROOT_W'(rem_reg > SQ_W'(acc_low));
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        acc_reg  <= acc_next;
        bit_reg  <= bit_next;
        root_reg <= root_next;
    end

    assign busy = busy_reg;
    assign done = done_reg;
    assign root = root_reg;

    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> !busy_reg)
        else $error("sqrt started while busy");

    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |=> !done_reg)
        else $error("sqrt done held longer than one cycle");

    a_busy_from_start: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(busy_reg) |-> $past(start))
        else $error("sqrt went busy without start");

endmodule

>>> rtl/core/euclidean_city_distance_table_unit.sv
// Top level of the city distance table: coordinate store, sequencer and output register.
//
// Usage: the req channel carries beats of two kinds. A write beat (kind 0) stores
// coord_x and coord_y for city_index and gives no response; the block is ready
// again on the next cycle. A query beat (kind 1) gives one rsp beat holding the
// EUC_2D distance between from_city and to_city, rounded to nearest. An index at
// or above city_count (cfg_we/cfg_data) gives bad_index = 1 and span = 0; equal
// valid indices give span 0 at once.
// Sequence: after the accepting edge a regular query runs two store reads, a
// difference step, two passes through one shared multiplier, one add, then
// COORD_BITS + 1 steps of the bit-serial square root plus a rounding step,
// before the result reaches the output register. Rejected or equal-index queries
// skip these steps and go straight to the output step. req.ready is low while a
// query is in flight, so no new query is taken until the last one has left it.
// Stall: the result sits in an output register; a new item is accepted while it
// waits, but the next query result holds until rsp.ready takes the old one.
// Reset clears city_count and all control state. Store contents are undefined
// until written; no clearing pass is run.
module euclidean_city_distance_table_unit
    import ecdt_pkg::*;
#(
    parameter int MAX_CITIES = ECDT_MAX_CITIES,
    parameter int COORD_BITS = ECDT_COORD_BITS
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [COUNT_W-1:0] cfg_data,
    ecdt_req_if.sink           req,
    ecdt_rsp_if.source         rsp
);

    localparam int ADDR_W    = (MAX_CITIES > 1) ? $clog2(MAX_CITIES) : 1;
    localparam int IDX_EXT_W = (ADDR_W > INDEX_W) ? ADDR_W : INDEX_W;
    localparam int PAIR_W    = 2 * COORD_BITS;
    localparam int RAD_W     = 2 * COORD_BITS + 1;
    localparam int ROOT_W    = COORD_BITS + 1;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_RDA  = 4'd1;
    localparam logic [3:0] S_RDB  = 4'd2;
    localparam logic [3:0] S_DIFF = 4'd3;
    localparam logic [3:0] S_SQX  = 4'd4;
    localparam logic [3:0] S_SQY  = 4'd5;
    localparam logic [3:0] S_ADD  = 4'd6;
    localparam logic [3:0] S_ROOT = 4'd7;
    localparam logic [3:0] S_FIN  = 4'd8;

    logic [3:0]            state_reg,     state_next;
    logic [COUNT_W-1:0]    city_count_reg;
    logic [ADDR_W-1:0]     a_addr_reg,    a_addr_next;
    logic [ADDR_W-1:0]     b_addr_reg,    b_addr_next;
    logic [PAIR_W-1:0]     a_pair_reg;
    logic [PAIR_W-1:0]     rd_data_reg;
    logic [COORD_BITS-1:0] dx_reg,        dy_reg;
    logic [PAIR_W-1:0]     prod_reg;
    logic [PAIR_W-1:0]     sum_reg;
    logic [SPAN_W-1:0]     res_span_reg,  res_span_next;
    logic                  res_bad_reg,   res_bad_next;
    logic                  out_valid_reg, out_valid_next;
    logic [SPAN_W-1:0]     out_span_reg;
    logic                  out_bad_reg;

    logic [PAIR_W-1:0]     mem [MAX_CITIES];

    logic                  accept;
    logic                  load_out;
    logic                  wr_en;
    logic [ADDR_W-1:0]     wr_addr;
    logic [ADDR_W-1:0]     rd_addr;
    logic [ADDR_W-1:0]     from_addr;
    logic [ADDR_W-1:0]     to_addr;
    logic [IDX_EXT_W-1:0]  wr_idx_ext;
    logic [IDX_EXT_W-1:0]  from_idx_ext;
    logic [IDX_EXT_W-1:0]  to_idx_ext;
    logic                  wr_in_range;
    logic                  query_bad;
    logic                  query_same;
    logic [COORD_BITS:0]   diff_x;
    logic [COORD_BITS:0]   diff_y;
    logic [COORD_BITS-1:0] mul_op;
    logic [RAD_W-1:0]      radicand;
    logic                  sqrt_start;
    logic                  sqrt_busy;
    logic                  sqrt_done;
    logic [ROOT_W-1:0]     sqrt_root;

    assign accept   = req.valid && req.ready;
    assign load_out = (state_reg == S_FIN) && (!out_valid_reg || rsp.ready);

    assign wr_idx_ext   = IDX_EXT_W'(req.city_index);
    assign from_idx_ext = IDX_EXT_W'(req.from_city);
    assign to_idx_ext   = IDX_EXT_W'(req.to_city);
    assign wr_addr      = wr_idx_ext[ADDR_W-1:0];
    assign from_addr    = from_idx_ext[ADDR_W-1:0];
    assign to_addr      = to_idx_ext[ADDR_W-1:0];

    assign wr_in_range = 32'(req.city_index) < MAX_CITIES;
    assign wr_en       = accept && (req.kind == KIND_WRITE) && wr_in_range;

    assign query_bad = (COUNT_W'(req.from_city) >= city_count_reg) ||
                       (COUNT_W'(req.to_city)   >= city_count_reg) ||
                       (32'(req.from_city) >= MAX_CITIES) ||
                       (32'(req.to_city)   >= MAX_CITIES);
    assign query_same = (req.from_city == req.to_city);

    assign rd_addr = (state_reg == S_RDA) ? a_addr_reg : b_addr_reg;

    // x sits in the upper half of a pair, y in the lower
    assign diff_x = {a_pair_reg[PAIR_W-1], a_pair_reg[PAIR_W-1:COORD_BITS]}
                  - {rd_data_reg[PAIR_W-1], rd_data_reg[PAIR_W-1:COORD_BITS]};
    assign diff_y = {a_pair_reg[COORD_BITS-1], a_pair_reg[COORD_BITS-1:0]}
                  - {rd_data_reg[COORD_BITS-1], rd_data_reg[COORD_BITS-1:0]};

    assign mul_op     = (state_reg == S_SQX) ? dx_reg : dy_reg;
    assign radicand   = RAD_W'(sum_reg) + RAD_W'(prod_reg);
    assign sqrt_start = (state_reg == S_ADD);

    ecdt_sqrt #(
        .COORD_BITS (COORD_BITS)
    ) u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (sqrt_start),
        .radicand (radicand),
        .busy     (sqrt_busy),
        .done     (sqrt_done),
        .root     (sqrt_root)
    );

    always_comb
    begin
        state_next    = state_reg;
        a_addr_next   = a_addr_reg;
        b_addr_next   = b_addr_reg;
        res_span_next = res_span_reg;
        res_bad_next  = res_bad_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept && (req.kind == KIND_QUERY))
                begin
                    a_addr_next   = from_addr;
                    b_addr_next   = to_addr;
                    res_span_next = '0;
                    res_bad_next  = query_bad;
                    state_next    = (query_bad || query_same) ? S_FIN : S_RDA;
                end
            end
            S_RDA:  state_next = S_RDB;
            S_RDB:  state_next = S_DIFF;
            S_DIFF: state_next = S_SQX;
            S_SQX:  state_next = S_SQY;
            S_SQY:  state_next = S_ADD;
            S_ADD:  state_next = S_ROOT;
            S_ROOT:
            begin
                if (sqrt_done)
                begin
                    res_span_next = SPAN_W'(sqrt_root);
                    state_next    = S_FIN;
                end
            end
            S_FIN:
            begin
                if (load_out)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            city_count_reg <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                city_count_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        a_addr_reg   <= a_addr_next;
        b_addr_reg   <= b_addr_next;
        res_span_reg <= res_span_next;
        res_bad_reg  <= res_bad_next;
        if (state_reg == S_RDB)
        begin
            a_pair_reg <= rd_data_reg;
        end
        if (state_reg == S_DIFF)
        begin
            dx_reg <= diff_x[COORD_BITS] ? COORD_BITS'(-diff_x) : diff_x[COORD_BITS-1:0];
            dy_reg <= diff_y[COORD_BITS] ? COORD_BITS'(-diff_y) : diff_y[COORD_BITS-1:0];
        end
        if ((state_reg == S_SQX) || (state_reg == S_SQY))
        begin
            prod_reg <= mul_op * mul_op;
        end
        if (state_reg == S_SQY)
        begin
            sum_reg <= prod_reg;
        end
        if (load_out)
        begin
            out_span_reg <= res_span_reg;
            out_bad_reg  <= res_bad_reg;
        end
    end

    // coordinate store, one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= {req.coord_x, req.coord_y};
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign req.ready     = (state_reg == S_IDLE);
    assign rsp.valid     = out_valid_reg;
    assign rsp.span      = out_span_reg;
    assign rsp.bad_index = out_bad_reg;

    a_done_in_root: assert property (@(posedge clk) disable iff (!rst_n)
        sqrt_done |-> (state_reg == S_ROOT))
        else $error("square root finished outside the root state");

    a_root_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_ROOT) && !sqrt_done |-> sqrt_busy)
        else $error("waiting on an idle square root unit");

    a_write_no_beat: assert property (@(posedge clk) disable iff (!rst_n)
        accept && (req.kind == KIND_WRITE) |=> (state_reg == S_IDLE))
        else $error("write beat started a query sequence");

    a_fin_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FIN) && out_valid_reg && !rsp.ready |=> (state_reg == S_FIN))
        else $error("result overwrote a stalled response");

    a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_bad_reg |-> (out_span_reg == '0))
        else $error("rejected query carries a nonzero span");

endmodule
